// ----- design/keypad_four_function_calculator_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Calculator assertion macros
// Concurrent assertion helpers used by the calculator RTL.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_FOUR_FUNCTION_CALCULATOR_UNIT_DEFINES_SVH
`define KEYPAD_FOUR_FUNCTION_CALCULATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define KFC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define KFC_ASSERT(label, clk, rst_n, prop, msg)
`define KFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- design/kfc_pkg.sv -----
// ----------------------------------------------------------------------------
// Calculator package
// Shared constants, key and segment tables, and the ALU control struct.
// ----------------------------------------------------------------------------
package kfc_pkg;

  localparam int DigitsDefault = 8;
  localparam int OpW = 27;
  localparam int ResW = 54;
  localparam logic [53:0] ResultMax = 54'd99999999;
  localparam logic [7:0] KeyLast = 8'h1C;
  localparam logic [4:0] SymNone = 5'h10;
  localparam logic [4:0] SymEquals = 5'h0E;
  localparam logic [4:0] SymClear = 5'h0F;

  localparam logic [1:0] OpAdd = 2'd0;
  localparam logic [1:0] OpSub = 2'd1;
  localparam logic [1:0] OpMul = 2'd2;
  localparam logic [1:0] OpDiv = 2'd3;

  localparam logic [1:0] PhFirst = 2'd0;
  localparam logic [1:0] PhSecond = 2'd1;
  localparam logic [1:0] PhResult = 2'd2;

  // Start word to the ALU and its completion status.
  typedef struct packed {
    logic        start;
    logic [1:0]  op;
  } alu_ctl_t;

  typedef struct packed {
    logic        done;
    logic        bad;
  } alu_sts_t;

  // Raw scan code to symbol.
  function automatic logic [4:0] key_sym(input logic [7:0] code);
    logic [4:0] s;
    case (code)
      8'd1: s = 5'hD;  8'd2: s = 5'hF;  8'd3: s = 5'h0;  8'd4: s = 5'hE;
      8'd9: s = 5'hC;  8'd10: s = 5'h9; 8'd11: s = 5'h8; 8'd12: s = 5'h7;
      8'd17: s = 5'hB; 8'd18: s = 5'h6; 8'd19: s = 5'h5; 8'd20: s = 5'h4;
      8'd25: s = 5'hA; 8'd26: s = 5'h3; 8'd27: s = 5'h2; 8'd28: s = 5'h1;
      default: s = SymNone;
    endcase
    return s;
  endfunction

  // Decimal digit to seven-segment byte.
  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0: s = 8'hFC; 4'd1: s = 8'h0C; 4'd2: s = 8'hDA; 4'd3: s = 8'hF2;
      4'd4: s = 8'h66; 4'd5: s = 8'hB6; 4'd6: s = 8'hBE; 4'd7: s = 8'hE0;
      4'd8: s = 8'hFE; 4'd9: s = 8'hE6;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

// ----- design/kfc_alu.sv -----
// ----------------------------------------------------------------------------
// Calculator shift-add ALU
// An adder runs add, subtract and shift-add multiply, and a separate trial
// subtractor runs restoring divide; multiply and divide go one bit per cycle; result checked against the range.
// ----------------------------------------------------------------------------
module kfc_alu (
  input  logic                        clk,
  input  logic                        rst_n,
  input  kfc_pkg::alu_ctl_t           ctl,
  input  logic [kfc_pkg::OpW-1:0]     a,
  input  logic [kfc_pkg::OpW-1:0]     b,
  output kfc_pkg::alu_sts_t           sts,
  output logic [kfc_pkg::ResW-1:0]    result
);

  localparam int W = kfc_pkg::OpW;
  localparam int RW = kfc_pkg::ResW;

  logic          busy_r, busy_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic [RW-1:0] acc_r, acc_nxt;     // product, sum or quotient
  logic [W:0]    rem_r, rem_nxt;     // divide remainder
  logic [RW-1:0] mcand_r, mcand_nxt; // shifted multiplicand
  logic [W-1:0]  mplier_r, mplier_nxt;
  logic          done_r, done_nxt;
  logic          bad_r, bad_nxt;
  logic [W:0]    trial;
  logic [RW:0]   sum;

  // Adder for add, subtract and multiply; trial subtractor for divide.
  always_comb begin
    trial = {rem_r[W-1:0], mplier_r[W-1]} - {1'b0, b};
    sum = {1'b0, acc_r} + {1'b0, mcand_r};
  end

  always_comb begin
    busy_nxt = busy_r;
    op_nxt = op_r;
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    rem_nxt = rem_r;
    mcand_nxt = mcand_r;
    mplier_nxt = mplier_r;
    done_nxt = 1'b0;
    bad_nxt = bad_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      op_nxt = ctl.op;
      cnt_nxt = 5'(W);
      acc_nxt = '0;
      rem_nxt = '0;
      mcand_nxt = RW'(a);
      mplier_nxt = (ctl.op == kfc_pkg::OpDiv) ? a : b;
      bad_nxt = 1'b0;
      if (ctl.op == kfc_pkg::OpSub) mcand_nxt = ~RW'(b) + RW'(1);
      if (ctl.op == kfc_pkg::OpAdd) mcand_nxt = RW'(b);
      if (ctl.op == kfc_pkg::OpAdd || ctl.op == kfc_pkg::OpSub) acc_nxt = RW'(a);
    end else if (busy_r) begin
      case (op_r)
        kfc_pkg::OpAdd: begin
          acc_nxt = sum[RW-1:0];
          cnt_nxt = '0;
        end
        kfc_pkg::OpSub: begin
          acc_nxt = sum[RW-1:0];
          bad_nxt = (a < b);
          cnt_nxt = '0;
        end
        kfc_pkg::OpMul: begin
          if (mplier_r[0]) acc_nxt = sum[RW-1:0];
          mcand_nxt = {mcand_r[RW-2:0], 1'b0};
          mplier_nxt = {1'b0, mplier_r[W-1:1]};
          cnt_nxt = cnt_r - 5'd1;
        end
        default: begin
          // Restoring divide, quotient bit per cycle.
          if (!trial[W]) begin
            rem_nxt = {1'b0, trial[W-1:0]};
            acc_nxt = {acc_r[RW-2:0], 1'b1};
          end else begin
            rem_nxt = {rem_r[W-1:0], mplier_r[W-1]};
            acc_nxt = {acc_r[RW-2:0], 1'b0};
          end
          mplier_nxt = {mplier_r[W-2:0], 1'b0};
          bad_nxt = (b == '0);
          cnt_nxt = cnt_r - 5'd1;
        end
      endcase
      if (cnt_nxt == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r <= op_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    mcand_r <= mcand_nxt;
    mplier_r <= mplier_nxt;
    bad_r <= bad_nxt;
  end

  assign result = acc_r;
  assign sts.done = done_r;
  assign sts.bad = bad_r || (acc_r > kfc_pkg::ResultMax);

endmodule

// ----- design/keypad_four_function_calculator_unit.sv -----
// A key or timeout word goes from acceptance to the output register and is
// held there until out_ready is high. An equals word starts the ALU, which
// runs add or subtract directly and multiply or divide one bit per cycle;
// the result is handed on, then split into decimal digits one digit per
// cycle by a divide-by-ten step, up to 8 digits, and the result word goes
// to the output register. An invalid result skips the digit split. in_ready
// is low meanwhile; the result word waits in an output register until
// taken.
// ----------------------------------------------------------------------------
// Keypad four-function calculator
// Key decode, operand entry, sequencing of the ALU and digit conversion.
// ----------------------------------------------------------------------------
`include "keypad_four_function_calculator_unit_defines.svh"
module keypad_four_function_calculator_unit #(
  parameter int DIGITS = kfc_pkg::DigitsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [7:0]  in_key_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_display_segments,
  output logic [3:0]  out_shown_digits,
  output logic [1:0]  out_phase,
  output logic        out_key_accepted,
  output logic        out_error_cleared
);

  localparam int W = kfc_pkg::OpW;
  localparam int RW = kfc_pkg::ResW;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StAlu = 3'd1;
  localparam logic [2:0] StConv = 3'd2;
  localparam logic [2:0] StOut = 3'd3;

  logic [2:0]    st_r, st_nxt;
  logic [W-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic [1:0]    opc_r, opc_nxt, ph_r, ph_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  logic [7:0]    buf_r [8];
  logic [7:0]    buf_nxt [8];
  logic [RW-1:0] val_r, val_nxt;     // value being split into digits
  logic [3:0]    n_r, n_nxt;
  logic [7:0]    tmp_r [8];
  logic [7:0]    tmp_nxt [8];
  logic          acc_r, acc_nxt, err_r, err_nxt;
  kfc_pkg::alu_ctl_t ctl;
  kfc_pkg::alu_sts_t sts;
  logic [RW-1:0] res;
  logic [4:0]    sym;
  logic [W-1:0]  opnd, opnd10;
  logic [26:0]   q10;
  logic [3:0]    r10;
  logic [53:0]   qprod;

  kfc_alu u_alu (.clk(clk), .rst_n(rst_n), .ctl(ctl), .a(a_r), .b(b_r),
                 .sts(sts), .result(res));

  // Divide by ten by reciprocal multiply; value is at most 99999999.
  always_comb begin
    qprod = 54'(val_r[26:0]) * 54'd13421773;
    q10 = 27'(qprod >> 27);
    r10 = 4'(val_r[26:0] - 27'(q10 * 27'd10));
    if (r10 > 4'd9) begin
      q10 = q10 - 27'd1;
      r10 = r10 + 4'd10;
    end
  end

  always_comb begin
    sym = (in_key_code != 8'd0 && in_key_code <= kfc_pkg::KeyLast)
          ? kfc_pkg::key_sym(in_key_code) : kfc_pkg::SymNone;
    opnd = (ph_r == kfc_pkg::PhFirst) ? a_r : b_r;
    opnd10 = W'(opnd * W'(10) + W'(sym[3:0]));
  end

  // Sequencer.
  always_comb begin
    st_nxt = st_r; a_nxt = a_r; b_nxt = b_r; opc_nxt = opc_r; ph_nxt = ph_r;
    cnt_nxt = cnt_r; buf_nxt = buf_r; val_nxt = val_r; n_nxt = n_r;
    tmp_nxt = tmp_r; acc_nxt = acc_r; err_nxt = err_r;
    ctl.start = 1'b0;
    ctl.op = opc_r;
    case (st_r)
      StIdle: begin
        if (in_valid) begin
          acc_nxt = 1'b0;
          err_nxt = 1'b0;
          st_nxt = StOut;
          if (in_opcode) begin
            a_nxt = '0; b_nxt = '0; ph_nxt = kfc_pkg::PhFirst; cnt_nxt = '0;
            buf_nxt = '{default: 8'h00};
          end else if (sym != kfc_pkg::SymNone) begin
            acc_nxt = 1'b1;
            if (sym == kfc_pkg::SymClear || ph_r >= kfc_pkg::PhResult) begin
              a_nxt = '0; b_nxt = '0; ph_nxt = kfc_pkg::PhFirst; cnt_nxt = '0;
              buf_nxt = '{default: 8'h00};
            end else if (sym <= 5'd9) begin
              if (32'(cnt_r) < DIGITS) begin
                if (ph_r == kfc_pkg::PhFirst) a_nxt = opnd10;
                else b_nxt = opnd10;
                if (cnt_r < 4'd8) buf_nxt[cnt_r[2:0]] = kfc_pkg::seg_of(sym[3:0]);
                cnt_nxt = cnt_r + 4'd1;
              end
            end else if (sym < kfc_pkg::SymEquals) begin
              if (ph_r == kfc_pkg::PhFirst) begin
                opc_nxt = 2'(sym - 5'hA);
                buf_nxt = '{default: 8'h00};
                cnt_nxt = '0;
                ph_nxt = kfc_pkg::PhSecond;
              end
            end else if (ph_r == kfc_pkg::PhSecond) begin
              ctl.start = 1'b1;
              st_nxt = StAlu;
            end
          end
        end
      end
      StAlu: begin
        if (sts.done) begin
          if (sts.bad) begin
            err_nxt = 1'b1;
            a_nxt = '0; b_nxt = '0; ph_nxt = kfc_pkg::PhFirst; cnt_nxt = '0;
            buf_nxt = '{default: 8'h00};
            st_nxt = StOut;
          end else begin
            val_nxt = res;
            n_nxt = '0;
            st_nxt = StConv;
          end
        end
      end
      StConv: begin
        // One decimal digit per cycle, least significant first.
        tmp_nxt[n_r[2:0]] = kfc_pkg::seg_of(r10);
        val_nxt = RW'(q10);
        n_nxt = n_r + 4'd1;
        if (q10 == '0 || n_r == 4'd7) begin
          buf_nxt = '{default: 8'h00};
          for (int i = 0; i < 8; i++) begin
            if (4'(i) < n_nxt) buf_nxt[i] = tmp_nxt[3'(n_r - 4'(i))];
          end
          cnt_nxt = n_nxt;
          ph_nxt = kfc_pkg::PhResult;
          st_nxt = StOut;
        end
      end
      StOut: begin
        if (out_ready) st_nxt = StIdle;
      end
      default: st_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= StIdle;
      a_r <= '0;
      b_r <= '0;
      opc_r <= kfc_pkg::OpAdd;
      ph_r <= kfc_pkg::PhFirst;
      cnt_r <= '0;
      buf_r <= '{default: 8'h00};
    end else begin
      st_r <= st_nxt;
      a_r <= a_nxt;
      b_r <= b_nxt;
      opc_r <= opc_nxt;
      ph_r <= ph_nxt;
      cnt_r <= cnt_nxt;
      buf_r <= buf_nxt;
    end
    val_r <= val_nxt;
    n_r <= n_nxt;
    tmp_r <= tmp_nxt;
    acc_r <= acc_nxt;
    err_r <= err_nxt;
  end

  assign in_ready = (st_r == StIdle);
  assign out_valid = (st_r == StOut);
  assign out_display_segments = {buf_r[7], buf_r[6], buf_r[5], buf_r[4],
                                 buf_r[3], buf_r[2], buf_r[1], buf_r[0]};
  assign out_shown_digits = cnt_r;
  assign out_phase = ph_r;
  assign out_key_accepted = acc_r;
  assign out_error_cleared = err_r;

  `KFC_ASSERT(a_no_overlap, clk, rst_n, !(in_ready && out_valid), "ready while word pending")
  `KFC_ASSERT(a_err_clears, clk, rst_n, !(out_valid && out_error_cleared) || (ph_r == kfc_pkg::PhFirst && cnt_r == 4'd0), "error did not clear")
  `KFC_ASSERT_NEXT(a_alu_done, clk, rst_n, sts.done, st_r != StAlu, "ALU done ignored")
  `KFC_ASSERT(a_cnt_range, clk, rst_n, 32'(cnt_r) <= DIGITS, "digit count over limit")

endmodule
